/* hw/rtl/jem_pkg.sv */
// Shared types and constants for the joystick event to key mapper.
`timescale 1ns / 1ps

package jem_pkg;

  // Default sizes of the button bitmap and the axis table
  localparam int NUM_BUTTONS_DEF = 32;
  localparam int NUM_AXES_DEF    = 32;

  // Results of one release burst beyond this count are dropped
  localparam int MAX_RESULTS = 64;

  // Key code bases
  localparam logic [9:0] CODE_BTN = 10'h100;
  localparam logic [9:0] CODE_NEG = 10'h200;
  localparam logic [9:0] CODE_POS = 10'h300;

  localparam logic [14:0] DEAD_ZONE_RST = 15'd8192;

  // Request types
  localparam logic [1:0] REQ_RAW  = 2'd0;
  localparam logic [1:0] REQ_DISC = 2'd1;
  localparam logic [1:0] REQ_CONN = 2'd2;

  // Raw event types, init flag removed
  localparam logic [6:0] EV_BUTTON = 7'h01;
  localparam logic [6:0] EV_AXIS   = 7'h02;

  // Configuration register indexes
  localparam logic REG_DEAD_ZONE   = 1'b0;
  localparam logic REG_REPORT_INIT = 1'b1;

  typedef struct packed {
    logic [9:0] code;
    logic       down;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    JOB_KEY1  = 2'd0,
    JOB_KEY2  = 2'd1,
    JOB_SWEEP = 2'd2
  } job_kind_t;

endpackage

/* hw/rtl/joystick_event_to_key_mapper.sv */
// Top level of the joystick event to key mapper.
`timescale 1ns / 1ps
//
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+-----------------------------------------
// in_      | in  | in_tvalid/in_tready | tuser: req_type; tdata: kind,index,level
// out_     | out | out_tvalid/tready   | tdata: key_code,key_down; tlast: last
// cfg_     | in  | cfg_we              | cfg_addr: register, cfg_wdata: value
//
// A button or axis item leaves the job queue when the back is idle; its keys
// then go into the output register in turn, waiting while it is stalled. A
// disconnect walks the buttons, then the axes, one per cycle but pausing on a
// held key while the output is stalled. in_tready drops while the two-entry
// job queue is full. Synchronous reset empties the queue, clears held buttons,
// active axes and output valid, and sets dead_zone 8192, init off.

module joystick_event_to_key_mapper #(
  parameter int NUM_BUTTONS = jem_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = jem_pkg::NUM_AXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: index 0 dead_zone, index 1 report_init_events
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_wdata,
  // events
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] event_kind, [15:8] event_index,
                                  // [31:16] event_level (signed)
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // keys
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] key_code, [10] key_down, rest zero
  output logic        out_tlast   // last key caused by an item
);

  localparam int JW = 2 + 2 * jem_pkg::KEY_W + NUM_BUTTONS + 2 * NUM_AXES;

  logic                   acc;
  logic                   q_full;
  logic                   q_push;
  jem_pkg::job_kind_t     f_kind;
  jem_pkg::key_t          f_k0, f_k1;
  logic [NUM_BUTTONS-1:0] f_btn;
  logic [NUM_AXES-1:0]    f_act, f_neg;
  logic [JW-1:0]          f_job;

  logic                   q_pop, q_valid;
  logic [JW-1:0]          b_job;
  jem_pkg::job_kind_t     b_kind;
  jem_pkg::key_t          b_k0, b_k1;
  logic [NUM_BUTTONS-1:0] b_btn;
  logic [NUM_AXES-1:0]    b_act, b_neg;

  jem_pkg::key_t          o_key;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  jem_front #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .req_type    (in_tuser),
    .event_kind  (in_tdata[7:0]),
    .event_index (in_tdata[15:8]),
    .event_level (in_tdata[31:16]),
    .q_push      (q_push),
    .q_kind      (f_kind),
    .q_k0        (f_k0),
    .q_k1        (f_k1),
    .q_btn       (f_btn),
    .q_act       (f_act),
    .q_neg       (f_neg)
  );

  assign f_job = {f_kind, f_k0, f_k1, f_btn, f_act, f_neg};

  jem_fifo #(
    .WIDTH (JW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (f_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (b_job)
  );

  assign {b_kind, b_k0, b_k1, b_btn, b_act, b_neg} = b_job;

  jem_back #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_kind    (b_kind),
    .q_k0      (b_k0),
    .q_k1      (b_k1),
    .q_btn     (b_btn),
    .q_act     (b_act),
    .q_neg     (b_neg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_key   (o_key),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b00000, o_key.down, o_key.code};

endmodule

/* hw/rtl/jem_fifo.sv */
// Two-entry job queue between the front and the back.
`timescale 1ns / 1ps

module jem_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rptr_r];

endmodule

/* hw/rtl/jem_front.sv */
// Front end: accepts events, keeps button and axis state, issues jobs.
`timescale 1ns / 1ps

module jem_front #(
  parameter int NUM_BUTTONS = jem_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = jem_pkg::NUM_AXES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [14:0]           cfg_wdata,
  // event
  input  logic                  acc,
  input  logic [1:0]            req_type,
  input  logic [7:0]            event_kind,
  input  logic [7:0]            event_index,
  input  logic [15:0]           event_level,
  // job out
  output logic                  q_push,
  output jem_pkg::job_kind_t    q_kind,
  output jem_pkg::key_t         q_k0,
  output jem_pkg::key_t         q_k1,
  output logic [NUM_BUTTONS-1:0] q_btn,
  output logic [NUM_AXES-1:0]   q_act,
  output logic [NUM_AXES-1:0]   q_neg
);

  localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic [14:0]            dead_zone_r;
  logic                   report_init_r;
  logic [NUM_BUTTONS-1:0] held_r, held_nxt;
  logic [NUM_AXES-1:0]    act_r, act_nxt;   // axis off center
  logic [NUM_AXES-1:0]    neg_r, neg_nxt;   // direction when active

  logic                   report;
  logic [6:0]             ev_type;
  logic [14:0]            dz;
  logic signed [16:0]     lvl;
  logic signed [16:0]     dz_s;
  logic                   new_neg, new_pos;
  logic                   old_act, old_neg;
  logic [BW-1:0]          bidx;
  logic [AW-1:0]          aidx;
  logic [9:0]             idx10;

  assign report  = report_init_r | ~event_kind[7];
  assign ev_type = event_kind[6:0];
  assign dz      = (dead_zone_r == 15'd0) ? 15'd1 : dead_zone_r;
  assign lvl     = {event_level[15], event_level};
  assign dz_s    = {2'b00, dz};
  assign new_neg = (lvl <= -dz_s);
  assign new_pos = !new_neg && (lvl >= dz_s);
  assign bidx    = event_index[BW-1:0];
  assign aidx    = event_index[AW-1:0];
  assign old_act = act_r[aidx];
  assign old_neg = neg_r[aidx];
  assign idx10   = {2'b00, event_index};

  always_comb begin
    held_nxt = held_r;
    act_nxt  = act_r;
    neg_nxt  = neg_r;
    q_push   = 1'b0;
    q_kind   = jem_pkg::JOB_KEY1;
    q_k0     = '0;
    q_k1     = '0;
    q_btn    = held_r;
    q_act    = act_r;
    q_neg    = neg_r;
    if (acc) begin
      unique case (req_type)
        jem_pkg::REQ_RAW: begin
          if (ev_type == jem_pkg::EV_BUTTON &&
              event_index < 8'(NUM_BUTTONS)) begin
            held_nxt[bidx] = (event_level != 16'd0);
            q_push         = report;
            q_k0.code      = jem_pkg::CODE_BTN | idx10;
            q_k0.down      = (event_level != 16'd0);
          end else if (ev_type == jem_pkg::EV_AXIS &&
                       event_index < 8'(NUM_AXES)) begin
            act_nxt[aidx] = new_neg | new_pos;
            neg_nxt[aidx] = new_neg;
            if ((old_act != (new_neg | new_pos)) ||
                (old_act && old_neg != new_neg)) begin
              q_push = report;
              if (old_act) begin
                // release of the old direction first
                q_k0.code = (old_neg ? jem_pkg::CODE_NEG : jem_pkg::CODE_POS) | idx10;
                q_k0.down = 1'b0;
                q_k1.code = (new_neg ? jem_pkg::CODE_NEG : jem_pkg::CODE_POS) | idx10;
                q_k1.down = 1'b1;
                q_kind    = (new_neg | new_pos) ? jem_pkg::JOB_KEY2 : jem_pkg::JOB_KEY1;
              end else begin
                q_k0.code = (new_neg ? jem_pkg::CODE_NEG : jem_pkg::CODE_POS) | idx10;
                q_k0.down = 1'b1;
              end
            end
          end
        end
        jem_pkg::REQ_DISC: begin
          held_nxt = '0;
          act_nxt  = '0;
          neg_nxt  = '0;
          q_kind   = jem_pkg::JOB_SWEEP;
          q_push   = (|held_r) | (|act_r);
        end
        jem_pkg::REQ_CONN: begin
          held_nxt = '0;
          act_nxt  = '0;
          neg_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r   <= jem_pkg::DEAD_ZONE_RST;
      report_init_r <= 1'b0;
      held_r        <= '0;
      act_r         <= '0;
      neg_r         <= '0;
    end else begin
      held_r <= held_nxt;
      act_r  <= act_nxt;
      neg_r  <= neg_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          jem_pkg::REG_DEAD_ZONE:   dead_zone_r   <= cfg_wdata;
          jem_pkg::REG_REPORT_INIT: report_init_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/jem_back.sv */
// Back end: plays out jobs as key results through an output register.
`timescale 1ns / 1ps

module jem_back #(
  parameter int NUM_BUTTONS = jem_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = jem_pkg::NUM_AXES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  jem_pkg::job_kind_t     q_kind,
  input  jem_pkg::key_t          q_k0,
  input  jem_pkg::key_t          q_k1,
  input  logic [NUM_BUTTONS-1:0] q_btn,
  input  logic [NUM_AXES-1:0]    q_act,
  input  logic [NUM_AXES-1:0]    q_neg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output jem_pkg::key_t          out_key,
  output logic                   out_last
);

  localparam int NMAX  = (NUM_BUTTONS > NUM_AXES) ? NUM_BUTTONS : NUM_AXES;
  localparam int IW    = $clog2(NMAX + 1);
  localparam int CW    = $clog2(jem_pkg::MAX_RESULTS);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_KEYS,
    BK_BTN,
    BK_AXIS
  } bk_state_t;

  bk_state_t              st_r;
  jem_pkg::key_t          k0_r, k1_r;
  logic                   two_r;
  logic [NUM_BUTTONS-1:0] btn_r;
  logic [NUM_AXES-1:0]    act_r, neg_r;
  logic [IW-1:0]          idx_r;
  logic [CW-1:0]          cnt_r;
  logic                   ovld_r;
  jem_pkg::key_t          okey_r;
  logic                   olast_r;

  logic                   out_free;
  logic                   emit;
  logic                   btn_rest, axis_rest;
  logic                   cap_hit;
  logic [9:0]             idx10;
  logic [NUM_BUTTONS-1:0] btn_sh;
  logic [NUM_AXES-1:0]    act_sh, neg_sh;

  assign out_free  = !ovld_r || out_ready;
  // a key is loaded into the output register this cycle
  assign emit      = out_free && ((st_r == BK_KEYS) ||
                                  (st_r == BK_BTN && btn_r[0]) ||
                                  (st_r == BK_AXIS && act_r[0]));
  assign btn_sh    = btn_r >> 1;
  assign act_sh    = act_r >> 1;
  assign neg_sh    = neg_r >> 1;
  assign btn_rest  = (|btn_sh) || (|act_r);
  assign axis_rest = |act_sh;
  assign cap_hit   = (cnt_r == CW'(jem_pkg::MAX_RESULTS - 1));
  assign idx10     = 10'(idx_r);
  assign q_pop     = (st_r == BK_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ovld_r <= 1'b0;
    end else begin
      if (emit) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
      unique case (st_r)
        BK_IDLE: begin
          if (q_valid) begin
            k0_r  <= q_k0;
            k1_r  <= q_k1;
            two_r <= (q_kind == jem_pkg::JOB_KEY2);
            btn_r <= q_btn;
            act_r <= q_act;
            neg_r <= q_neg;
            idx_r <= '0;
            cnt_r <= '0;
            st_r  <= (q_kind == jem_pkg::JOB_SWEEP) ? BK_BTN : BK_KEYS;
          end
        end
        BK_KEYS: begin
          if (out_free) begin
            okey_r  <= k0_r;
            olast_r <= !two_r;
            k0_r    <= k1_r;
            two_r   <= 1'b0;
            if (!two_r) begin
              st_r <= BK_IDLE;
            end
          end
        end
        BK_BTN: begin
          if (!btn_r[0] || out_free) begin
            btn_r <= btn_sh;
            idx_r <= (idx_r == IW'(NUM_BUTTONS - 1)) ? '0 : idx_r + 1'b1;
            if (btn_r[0] && (!btn_rest || cap_hit)) begin
              st_r <= BK_IDLE;
            end else if (idx_r == IW'(NUM_BUTTONS - 1)) begin
              st_r <= BK_AXIS;
            end
            if (btn_r[0]) begin
              okey_r.code  <= jem_pkg::CODE_BTN | idx10;
              okey_r.down  <= 1'b0;
              olast_r      <= !btn_rest || cap_hit;
              cnt_r        <= cnt_r + 1'b1;
            end
          end
        end
        BK_AXIS: begin
          if (!act_r[0] || out_free) begin
            act_r <= act_sh;
            neg_r <= neg_sh;
            idx_r <= idx_r + 1'b1;
            if (act_r[0]) begin
              okey_r.code <= (neg_r[0] ? jem_pkg::CODE_NEG : jem_pkg::CODE_POS) | idx10;
              okey_r.down <= 1'b0;
              olast_r     <= !axis_rest || cap_hit;
              cnt_r       <= cnt_r + 1'b1;
              if (!axis_rest || cap_hit) begin
                st_r <= BK_IDLE;
              end
            end
          end
        end
        default: st_r <= BK_IDLE;
      endcase
    end
  end

  assign out_valid = ovld_r;
  assign out_key   = okey_r;
  assign out_last  = olast_r;

endmodule
